FILE: src/cht_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table engine.
package cht_pkg;

  localparam int BUCKETS_DEF    = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // link/used memory write operations
  localparam logic [2:0] MW_NONE       = 3'd0;
  localparam logic [2:0] MW_HEAD_NEW   = 3'd1;
  localparam logic [2:0] MW_HEAD_EMPTY = 3'd2;
  localparam logic [2:0] MW_PREV_LINK  = 3'd3;
  localparam logic [2:0] MW_CUR_NEW    = 3'd4;
  localparam logic [2:0] MW_LAST_LINK  = 3'd5;
  localparam logic [2:0] MW_CUR_FREE   = 3'd6;
  localparam logic [2:0] MW_HEAD_COPY  = 3'd7;

  // key/hash/value memory write operations
  localparam logic [1:0] DW_NONE      = 2'd0;
  localparam logic [1:0] DW_REQ_CUR   = 2'd1;
  localparam logic [1:0] DW_REQ_HEAD  = 2'd2;
  localparam logic [1:0] DW_COPY_HEAD = 2'd3;

  typedef struct packed {
    logic       clear_wr;
    logic       accept;
    logic       walk;
    logic [2:0] mw_op;
    logic [1:0] dw_op;
    logic       rd_free;
    logic       rd_cur_link;
    logic       pop_free;
    logic       res_load;
    logic [1:0] res_code;
    logic       res_found;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       walk_done;
    logic       hit;
    logic       head_used;
    logic       free_empty;
    logic       cur_is_head;
    logic       cur_link_nil;
    logic [1:0] req_type;
    logic       out_busy;
  } stat_t;

endpackage

FILE: src/cht_ctrl.sv
// Controller state machine: clearing pass, chain walk and update sequencing.
module cht_ctrl import cht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;
  localparam logic [3:0] S_ADD2  = 4'd4;
  localparam logic [3:0] S_ADD3  = 4'd5;
  localparam logic [3:0] S_RMH   = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mw_op = MW_NONE;
    cmd.dw_op = DW_NONE;
    cmd.res_code = ST_NOT_FOUND;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_done) state_next = S_OP;
      end
      S_OP: begin
        cmd.res_load = 1'b1;
        state_next = S_DONE;
        unique case (st.req_type)
          REQ_LOOKUP: begin
            cmd.res_code  = st.hit ? ST_OK : ST_NOT_FOUND;
            cmd.res_found = st.hit;
          end
          REQ_ADD: begin
            cmd.res_code = ST_OK;
            priority if (st.hit) begin
              cmd.dw_op = DW_REQ_CUR;
            end else if (!st.head_used) begin
              cmd.dw_op = DW_REQ_HEAD;
              cmd.mw_op = MW_HEAD_NEW;
            end else if (st.free_empty) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.res_load = 1'b0;
              cmd.rd_free  = 1'b1;
              state_next   = S_ADD2;
            end
          end
          REQ_REMOVE: begin
            if (st.hit) begin
              cmd.res_code  = ST_OK;
              cmd.res_found = 1'b1;
              priority if (st.cur_is_head && st.cur_link_nil) begin
                cmd.mw_op = MW_HEAD_EMPTY;
              end else if (st.cur_is_head) begin
                cmd.rd_cur_link = 1'b1;
                state_next = S_RMH;
              end else begin
                cmd.mw_op  = MW_PREV_LINK;
                state_next = S_FREE;
              end
            end
          end
          default: begin
            cmd.res_code = ST_NOT_FOUND;
          end
        endcase
      end
      S_ADD2: begin
        cmd.pop_free = 1'b1;
        cmd.mw_op    = MW_CUR_NEW;
        cmd.dw_op    = DW_REQ_CUR;
        state_next   = S_ADD3;
      end
      S_ADD3: begin
        cmd.mw_op    = MW_LAST_LINK;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_RMH: begin
        cmd.mw_op  = MW_HEAD_COPY;
        cmd.dw_op  = DW_COPY_HEAD;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.mw_op  = MW_CUR_FREE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/cht_datapath.sv
// Datapath: slot memories, walk registers, free list head and result register.
module cht_datapath import cht_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] key_hash,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] result_value
);

  localparam int TOTAL = BUCKETS + BUCKETS / 4;
  localparam int IDX_W = $clog2(TOTAL);
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DW    = 32 + KW + VW;
  localparam int MW    = 1 + IDX_W;

  logic [MW-1:0] meta_mem [TOTAL];
  logic [DW-1:0] data_mem [TOTAL];
  logic [MW-1:0] meta_rd;
  logic [DW-1:0] data_rd;

  logic [IDX_W-1:0] raddr;
  logic             meta_we;
  logic [IDX_W-1:0] meta_wa;
  logic [MW-1:0]    meta_wd;
  logic             data_we;
  logic [IDX_W-1:0] data_wa;
  logic [DW-1:0]    data_wd;

  // request and walk registers
  logic [1:0]       r_type;
  logic [KW-1:0]    r_key;
  logic [31:0]      r_hash;
  logic [VW-1:0]    r_value;
  logic [IDX_W-1:0] head, p, q, last, cur, cur_link, free_head, clr_idx;
  logic             first, hit, head_used;
  logic [VW-1:0]    found;
  logic [1:0]       res_code;
  logic [VW-1:0]    res_val;

  logic             rd_used;
  logic [IDX_W-1:0] rd_link;
  logic [31:0]      rd_hash;
  logic [KW-1:0]    rd_key;
  logic [VW-1:0]    rd_value;
  logic             match;
  logic [IDX_W-1:0] bucket;
  logic [IDX_W-1:0] init_link;

  assign {rd_used, rd_link} = meta_rd;
  assign {rd_hash, rd_key, rd_value} = data_rd;
  assign match  = rd_used && (rd_hash == r_hash) && (rd_key == r_key);
  assign bucket = IDX_W'(key_hash[BKT_W-1:0]);
  assign init_link = ((clr_idx >= IDX_W'(BUCKETS)) && (clr_idx != IDX_W'(TOTAL - 1)))
                     ? clr_idx + 1'b1 : '0;

  always_comb begin
    raddr = p;
    if (cmd.accept) raddr = bucket;
    else if (cmd.walk) raddr = rd_link;
    else if (cmd.rd_free) raddr = free_head;
    else if (cmd.rd_cur_link) raddr = cur_link;
  end

  always_comb begin
    meta_we = 1'b1;
    meta_wa = head;
    meta_wd = {1'b1, {IDX_W{1'b0}}};
    unique case (cmd.mw_op)
      MW_NONE: begin
        meta_we = cmd.clear_wr;
        meta_wa = clr_idx;
        meta_wd = {1'b0, init_link};
      end
      MW_HEAD_NEW:   meta_wd = {1'b1, {IDX_W{1'b0}}};
      MW_HEAD_EMPTY: meta_wd = {1'b0, {IDX_W{1'b0}}};
      MW_PREV_LINK: begin
        meta_wa = q;
        meta_wd = {1'b1, cur_link};
      end
      MW_CUR_NEW: begin
        meta_wa = cur;
        meta_wd = {1'b1, {IDX_W{1'b0}}};
      end
      MW_LAST_LINK: begin
        meta_wa = last;
        meta_wd = {1'b1, cur};
      end
      MW_CUR_FREE: begin
        meta_wa = cur;
        meta_wd = {1'b0, free_head};
      end
      MW_HEAD_COPY:  meta_wd = {1'b1, rd_link};
      default:       meta_we = 1'b0;
    endcase
  end

  always_comb begin
    data_we = 1'b1;
    data_wa = head;
    data_wd = {r_hash, r_key, r_value};
    unique case (cmd.dw_op)
      DW_NONE:      data_we = 1'b0;
      DW_REQ_CUR:   data_wa = cur;
      DW_REQ_HEAD:  data_wa = head;
      DW_COPY_HEAD: data_wd = data_rd;
      default:      data_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (data_we) data_mem[data_wa] <= data_wd;
    meta_rd <= meta_mem[raddr];
    data_rd <= data_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      free_head <= IDX_W'(BUCKETS);
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_idx <= clr_idx + 1'b1;
      if (cmd.pop_free) free_head <= rd_link;
      else if (cmd.mw_op == MW_CUR_FREE) free_head <= cur;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_type    <= req_type;
      r_key     <= key[KW-1:0];
      r_hash    <= key_hash;
      r_value   <= value[VW-1:0];
      head      <= bucket;
      p         <= bucket;
      q         <= '0;
      last      <= bucket;
      first     <= 1'b1;
      hit       <= 1'b0;
      head_used <= 1'b0;
    end
    if (cmd.walk) begin
      first <= 1'b0;
      if (first) head_used <= rd_used;
      if (match) begin
        hit      <= 1'b1;
        cur      <= p;
        cur_link <= rd_link;
        found    <= rd_value;
      end else begin
        last <= p;
        if (rd_used && (rd_link != '0)) begin
          q <= p;
          p <= rd_link;
        end
      end
    end
    if (cmd.rd_free) cur <= free_head;
    if (cmd.rd_cur_link) cur <= cur_link;
    if (cmd.res_load) begin
      res_code <= cmd.res_code;
      res_val  <= cmd.res_found ? found : '0;
    end
    if (cmd.out_load) begin
      status       <= res_code;
      result_value <= 32'(res_val);
    end
  end

  always_comb begin
    st.clear_last   = (clr_idx == IDX_W'(TOTAL - 1));
    st.walk_done    = match || !rd_used || (rd_link == '0);
    st.hit          = hit;
    st.head_used    = head_used;
    st.free_empty   = (free_head == '0);
    st.cur_is_head  = (cur == head);
    st.cur_link_nil = (cur_link == '0);
    st.req_type     = r_type;
    st.out_busy     = out_valid && out_stall;
  end

endmodule

FILE: src/chained_hash_table_engine.sv
// Hash table engine with bucket heads, an overflow area and one request in flight at a time.
// Requests (lookup, add/update, remove) arrive on the in_valid/in_stall channel with a key,
// its precomputed hash and a value; each gives exactly one result transfer on the
// out_valid/out_stall channel. The bucket is the low log2(BUCKETS) bits of key_hash; colliding
// keys chain into an overflow area of BUCKETS/4 slots held on a free list. An add that needs
// an overflow slot when none is free is refused with status 2. After reset the block runs a
// clearing pass over all BUCKETS + BUCKETS/4 slots of the link memory and takes no request
// until it ends. A request then goes through an accept step, a walk over the chain slots it
// visits (the slot memories have a single registered read port, so the walk reads one slot a
// cycle), a decision step, extra update steps where needed (S_ADD2 and S_ADD3 for an insert
// into the overflow area, S_RMH and S_FREE for a head remove that pulls up its successor,
// S_FREE alone for a remove behind the head) and a load of the output register; a finished
// result waits for that load while the previous one is still held on out_stall.
// The next request is taken while the previous result still waits in the output register.
module chained_hash_table_engine import cht_pkg::*; #(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] key,
  input  logic [31:0] key_hash,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] result_value
);

  cmd_t  cmd;
  stat_t st;

  // sequencing: clear pass, walk, update steps, result hand-off
  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // slot memories and all per-request registers
  cht_datapath #(
    .BUCKETS    (BUCKETS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .req_type     (req_type),
    .key          (key),
    .key_hash     (key_hash),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
  );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the chained hash table engine.
`timescale 1ns / 100ps

module testbench;
  import cht_pkg::*;

  localparam int BUCKETS   = BUCKETS_DEF;
  localparam int OVF       = BUCKETS / 4;
  localparam int TOTAL     = BUCKETS + OVF;
  localparam int NIL       = 0;
  localparam logic [1:0] REQ_BAD = 2'd3;  // unused request code
  localparam int POOL_SIZE = 96;
  localparam int HOT_BKTS  = 12;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] k;
    logic [31:0] h;
    logic [31:0] v;
    bit          drain;  // hold off until every reply is back
  } request_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] rv;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [31:0] key;
  logic [31:0] key_hash;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] result_value;

  chained_hash_table_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .key          (key),
    .key_hash     (key_hash),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Shadow copy of the table: heads at 0..BUCKETS-1, overflow area behind them.
  bit          tbl_used [TOTAL];
  logic [31:0] tbl_key  [TOTAL];
  logic [31:0] tbl_hash [TOTAL];
  logic [31:0] tbl_val  [TOTAL];
  int unsigned tbl_link [TOTAL];
  int unsigned free_top;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];
  int       errors;
  int       mismatches;

  // Reset state: overflow slots chained in order onto the free list.
  task automatic table_clear();
    for (int i = 0; i < TOTAL; i++) begin
      tbl_used[i] = 1'b0;
      tbl_link[i] = (i >= BUCKETS && i + 1 < TOTAL) ? i + 1 : NIL;
    end
    free_top = BUCKETS;
  endtask

  function automatic bit link_ok(int unsigned i);
    return i != NIL && i < TOTAL;
  endfunction

  function automatic bit slot_holds(int unsigned i, logic [31:0] k, logic [31:0] h);
    return tbl_used[i] && tbl_hash[i] == h && tbl_key[i] == k;
  endfunction

  // Applies one request to the shadow table and returns its reply.
  function automatic reply_t table_apply(request_t r);
    int unsigned hd, p, q, cur, prev, last, n;
    bit hit;
    reply_t rep;
    hd = r.h & (BUCKETS - 1);
    cur = NIL;
    prev = NIL;
    last = hd;
    hit = 1'b0;
    rep.st = ST_NOT_FOUND;
    rep.rv = '0;
    // chain walk: match, its predecessor, and the tail
    if (tbl_used[hd]) begin
      p = hd;
      q = NIL;
      for (int s = 0; s <= TOTAL; s++) begin
        if (slot_holds(p, r.k, r.h)) begin
          cur = p;
          prev = q;
          hit = 1'b1;
          break;
        end
        last = p;
        n = tbl_link[p];
        if (!link_ok(n)) break;
        q = p;
        p = n;
      end
    end
    case (r.req)
      REQ_LOOKUP: begin
        if (hit) begin
          rep.st = ST_OK;
          rep.rv = tbl_val[cur];
        end
      end
      REQ_ADD: begin
        if (hit) begin
          tbl_val[cur] = r.v;
          rep.st = ST_OK;
        end else if (!tbl_used[hd]) begin
          tbl_used[hd] = 1'b1;
          tbl_key[hd] = r.k;
          tbl_hash[hd] = r.h;
          tbl_val[hd] = r.v;
          tbl_link[hd] = NIL;
          rep.st = ST_OK;
        end else if (!link_ok(free_top)) begin
          rep.st = ST_FULL;
        end else begin
          n = free_top;
          free_top = tbl_link[n];
          tbl_used[n] = 1'b1;
          tbl_key[n] = r.k;
          tbl_hash[n] = r.h;
          tbl_val[n] = r.v;
          tbl_link[n] = NIL;
          tbl_link[last] = n;
          rep.st = ST_OK;
        end
      end
      REQ_REMOVE: begin
        if (hit) begin
          rep.rv = tbl_val[cur];
          rep.st = ST_OK;
          if (cur == hd) begin
            n = tbl_link[hd];
            if (link_ok(n)) begin
              // successor moves up into the head slot
              tbl_key[hd] = tbl_key[n];
              tbl_hash[hd] = tbl_hash[n];
              tbl_val[hd] = tbl_val[n];
              tbl_link[hd] = tbl_link[n];
              tbl_used[n] = 1'b0;
              tbl_link[n] = free_top;
              free_top = n;
            end else begin
              tbl_used[hd] = 1'b0;
              tbl_link[hd] = NIL;
            end
          end else begin
            tbl_link[prev] = tbl_link[cur];
            tbl_used[cur] = 1'b0;
            tbl_link[cur] = free_top;
            free_top = cur;
          end
        end
      end
      default: ;  // unknown code: not found, no change
    endcase
    return rep;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: next request goes out once the current one transfers.
  int in_gap;
  always @(posedge clk) begin
    request_t nxt;
    bit       busy;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        nxt.req = req_type;
        nxt.k = key;
        nxt.h = key_hash;
        nxt.v = value;
        nxt.drain = 1'b0;
        expected_replies.push_back(table_apply(nxt));
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_replies.size() > 0)) begin
          nxt = pending_reqs.pop_front();
          req_type <= nxt.req;
          key <= nxt.k;
          key_hash <= nxt.h;
          value <= nxt.v;
          in_valid <= 1'b1;
          in_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, check each reply against the oldest expectation.
  int out_gap;
  always @(posedge clk) begin
    reply_t exp_rep;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected reply: status %0d value %h", status, result_value);
        end else begin
          exp_rep = expected_replies.pop_front();
          if (status !== exp_rep.st || result_value !== exp_rep.rv) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d value %h, got status %0d value %h",
                       exp_rep.st, exp_rep.rv, status, result_value);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  // Key pool clustered on a few buckets so chains grow and the overflow area fills.
  logic [31:0] pool_key  [POOL_SIZE];
  logic [31:0] pool_hash [POOL_SIZE];
  logic [7:0]  hot_bkt   [HOT_BKTS];

  task automatic queue_req(logic [1:0] rq, logic [31:0] k, logic [31:0] h,
                           logic [31:0] v, bit drain = 1'b0);
    request_t r;
    r.req = rq;
    r.k = k;
    r.h = h;
    r.v = v;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  // Random segment; op mix shifts with the weights (add / remove percent).
  task automatic queue_random(int count, int add_pct, int rem_pct);
    int r, i, op;
    logic [31:0] k, h;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      i = $urandom_range(POOL_SIZE - 1);
      k = pool_key[i];
      h = pool_hash[i];
      if (r < 8) begin
        // noise, including the unknown request code
        queue_req(2'($urandom_range(3)), $urandom, $urandom, $urandom);
      end else begin
        if (r < 14) h[$urandom_range(31, 8)] ^= 1'b1;
        else if (r < 18) k[$urandom_range(31)] ^= 1'b1;
        op = $urandom_range(99);
        if (op < add_pct) queue_req(REQ_ADD, k, h, $urandom);
        else if (op < add_pct + rem_pct) queue_req(REQ_REMOVE, k, h, $urandom);
        else queue_req(REQ_LOOKUP, k, h, $urandom);
      end
    end
  endtask

  initial begin
    errors = 0;
    mismatches = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    req_type = REQ_LOOKUP;
    key = '0;
    key_hash = '0;
    value = '0;
    table_clear();

    hot_bkt[0] = 8'h00;
    hot_bkt[1] = 8'hFF;
    for (int i = 2; i < HOT_BKTS; i++) hot_bkt[i] = 8'($urandom_range(255));
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = {24'($urandom_range(32'h00FF_FFFF)),
                      hot_bkt[$urandom_range(HOT_BKTS - 1)]};
    end

    // Directed: empty table, extremes, update, chains, head and middle removal.
    queue_req(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
    queue_req(REQ_ADD,    32'h0, 32'h0, 32'hFFFF_FFFF);
    queue_req(REQ_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_req(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
    queue_req(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_req(REQ_ADD,    32'h0, 32'h0, 32'h1234_5678);  // update in place
    queue_req(REQ_ADD,    32'h5, 32'h0, 32'hA5A5_A5A5);  // chains behind head 0
    queue_req(REQ_ADD,    32'h0, 32'h100, 32'h5A5A_5A5A); // same key, other hash
    queue_req(REQ_ADD,    32'h7, 32'h0, 32'h0000_0007);
    queue_req(REQ_LOOKUP, 32'h0, 32'h100, 32'h0);
    queue_req(REQ_LOOKUP, 32'h0, 32'h200, 32'h0);        // same bucket, missing
    queue_req(REQ_REMOVE, 32'h0, 32'h0, 32'h0);          // head, successor moves up
    queue_req(REQ_LOOKUP, 32'h5, 32'h0, 32'h0);
    queue_req(REQ_REMOVE, 32'h0, 32'h100, 32'h0);        // middle of chain
    queue_req(REQ_LOOKUP, 32'h7, 32'h0, 32'h0);
    queue_req(REQ_BAD,    32'h7, 32'h0, 32'hFFFF_FFFF);
    queue_req(REQ_REMOVE, 32'h9, 32'h0, 32'h0);          // missing key
    queue_req(REQ_REMOVE, 32'h7, 32'h0, 32'h0);          // chain tail
    queue_req(REQ_REMOVE, 32'h5, 32'h0, 32'h0);          // lone head
    queue_req(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_req(REQ_LOOKUP, 32'h5, 32'h0, 32'h0);

    // Random: fill until full, churn, drain, then fill again.
    queue_random(350, 65, 10);
    queue_req(REQ_LOOKUP, pool_key[0], pool_hash[0], 32'h0, 1'b1);
    queue_random(350, 35, 35);
    queue_random(250, 10, 70);
    queue_random(250, 55, 25);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    errors += expected_replies.size();
    if (errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: filelist.f
src/cht_pkg.sv
src/cht_ctrl.sv
src/cht_datapath.sv
src/chained_hash_table_engine.sv
dv/testbench.sv
